[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ECI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define ECI_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ECI_ASSERT(label, prop, msg)
`define ECI_ASSERT_NEVER(label, cond, msg)
`endif
`endif

[sv/eci_pkg.sv]
// ----------------------------------------------------------------------------
// Easing curve interpolator package
// Formats, curve codes, the queued word type, the power table and the quarter sine table.
// ----------------------------------------------------------------------------
package eci_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int VALUE_WIDTH   = 24;
    localparam int TABLE_DEPTH   = 256;
    localparam int PROG_W        = FRACTION_BITS + 1;
    localparam int Q_BITS        = 30;
    localparam int TBL_AW        = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] LN2_Q30    = 64'd744261118;
    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

    localparam logic [PROG_W-1:0] PROG_ONE  = PROG_W'(1) << FRACTION_BITS;
    localparam logic [PROG_W-1:0] PROG_HALF = PROG_W'(1) << (FRACTION_BITS - 1);

    // Curve codes, equal to the mode numbers on the input side.
    localparam logic [3:0] MODE_LINEAR      = 4'd0;
    localparam logic [3:0] MODE_EXPO_IN     = 4'd1;
    localparam logic [3:0] MODE_EXPO_OUT    = 4'd2;
    localparam logic [3:0] MODE_EXPO_INOUT  = 4'd3;
    localparam logic [3:0] MODE_CUBIC_IN    = 4'd4;
    localparam logic [3:0] MODE_CUBIC_OUT   = 4'd5;
    localparam logic [3:0] MODE_CUBIC_INOUT = 4'd6;
    localparam logic [3:0] MODE_BOUNCE_OUT  = 4'd7;
    localparam logic [3:0] MODE_BOUNCE_IN   = 4'd8;
    localparam logic [3:0] MODE_ELASTIC_IN  = 4'd9;
    localparam logic [3:0] MODE_ELASTIC_OUT = 4'd10;

    typedef struct packed {
        logic [3:0]                    curve;
        logic [PROG_W-1:0]             prog;
        logic                          is_zero;
        logic                          is_one;
        logic signed [VALUE_WIDTH-1:0] start_value;
        logic signed [VALUE_WIDTH-1:0] end_value;
    } eci_item_t;

    typedef logic [Q_BITS:0] rom_t [0:TABLE_DEPTH];

    // Divides a term of the power series by k, the step number.
    function automatic logic [63:0] pow2_step_div(logic [63:0] v, int k);
        logic [63:0] q;
        case (k)
            2:       q = v / 64'd2;
            3:       q = v / 64'd3;
            4:       q = v / 64'd4;
            5:       q = v / 64'd5;
            6:       q = v / 64'd6;
            7:       q = v / 64'd7;
            8:       q = v / 64'd8;
            9:       q = v / 64'd9;
            10:      q = v / 64'd10;
            11:      q = v / 64'd11;
            12:      q = v / 64'd12;
            13:      q = v / 64'd13;
            14:      q = v / 64'd14;
            default: q = v;
        endcase
        return q;
    endfunction

    // Divides a term of the sine series by 2k * (2k + 1).
    function automatic logic [63:0] sin_step_div(logic [63:0] v, int k);
        logic [63:0] q;
        case (k)
            1:       q = v / 64'd6;
            2:       q = v / 64'd20;
            3:       q = v / 64'd42;
            4:       q = v / 64'd72;
            5:       q = v / 64'd110;
            6:       q = v / 64'd156;
            7:       q = v / 64'd210;
            8:       q = v / 64'd272;
            9:       q = v / 64'd342;
            10:      q = v / 64'd420;
            default: q = v;
        endcase
        return q;
    endfunction

    // 2^(-i/TABLE_DEPTH) in Q30 from a truncated series.
    function automatic rom_t build_pow2_rom();
        rom_t               rom;
        logic [63:0]        y;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            y    = (64'(i) * LN2_Q30 + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
            term = 64'(1) << Q_BITS;
            sum  = $signed(term);
            for (int k = 1; k <= 14; k++)
            begin
                term = pow2_step_div((term * y) >> Q_BITS, k);
                if ((k & 1) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 <<< Q_BITS))
                sum = 64'sd1 <<< Q_BITS;
            rom[i] = (Q_BITS + 1)'(sum);
        end
        return rom;
    endfunction

    // sin(pi/2 * i/TABLE_DEPTH) in Q30 from a truncated series.
    function automatic rom_t build_sin_rom();
        rom_t               rom;
        logic [63:0]        z;
        logic [63:0]        z2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            z    = (64'(i) * HALFPI_Q30 + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
            z2   = (z * z) >> Q_BITS;
            term = z;
            sum  = $signed(z);
            for (int k = 1; k <= 10; k++)
            begin
                term = sin_step_div((term * z2) >> Q_BITS, k);
                if ((k & 1) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 <<< Q_BITS))
                sum = 64'sd1 <<< Q_BITS;
            rom[i] = (Q_BITS + 1)'(sum);
        end
        return rom;
    endfunction

    localparam rom_t POW2_ROM = build_pow2_rom();
    localparam rom_t SIN_ROM  = build_sin_rom();

endpackage

[sv/easing_curve_interpolator.sv]
// ----------------------------------------------------------------------------
// Easing curve interpolator
// Applies an easing curve to a progress fraction and blends start to end.
//
//   Channel   Direction  Payload
//   s_axis    in         mode, progress, start_value, end_value
//   m_axis    out        eased_value (tdata), saturated (tuser)
//
// One word is accepted per cycle while the queue is not full, and one result
// leaves per cycle while the output is not stalled. A word waits in the
// four-entry queue and then passes the stage registers B to G and the output register.
// Reset clears the queue and the pipeline valid bits; no clearing pass.
// When the output stalls the pipeline holds and the queue keeps accepting
// until it is full.
// ----------------------------------------------------------------------------
module easing_curve_interpolator
    import eci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[3:0], progress[20:4], start_value[44:21], end_value[68:45], zero pad
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // eased_value[23:0]
    output logic [23:0] m_axis_tdata,
    // saturated[0]
    output logic        m_axis_tuser
);

    eci_item_t front_item;
    eci_item_t head_item;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;

    eci_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .push          (push),
        .item          (front_item)
    );

    eci_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_item),
        .full  (q_full),
        .pop   (pop),
        .dout  (head_item),
        .empty (q_empty)
    );

    eci_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[sv/eci_front.sv]
// ----------------------------------------------------------------------------
// Easing front end
// Unpacks an input word, clamps the progress and maps the mode to a curve.
// ----------------------------------------------------------------------------
module eci_front
    import eci_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[3:0], progress[20:4], start_value[44:21], end_value[68:45], zero pad
    input  logic [71:0] s_axis_tdata,
    input  logic        q_full,
    output logic        push,
    output eci_item_t   item
);

    logic [3:0]        mode;
    logic [PROG_W-1:0] progress;
    logic [PROG_W-1:0] prog;

    assign mode     = s_axis_tdata[3:0];
    assign progress = s_axis_tdata[20:4];

    // Progress beyond one is taken as exactly one.
    assign prog = (progress > PROG_ONE) ? PROG_ONE : progress;

    always_comb
    begin
        item.prog        = prog;
        item.is_zero     = (prog == '0);
        item.is_one      = (prog == PROG_ONE);
        item.start_value = $signed(s_axis_tdata[44:21]);
        item.end_value   = $signed(s_axis_tdata[68:45]);
        unique case (mode) inside
            MODE_LINEAR, MODE_EXPO_IN, MODE_EXPO_OUT, MODE_EXPO_INOUT,
            MODE_CUBIC_IN, MODE_CUBIC_OUT, MODE_CUBIC_INOUT,
            MODE_BOUNCE_OUT, MODE_BOUNCE_IN, MODE_ELASTIC_IN, MODE_ELASTIC_OUT:
                item.curve = mode;
            default:
                item.curve = MODE_LINEAR;
        endcase
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

endmodule

[sv/eci_queue.sv]
// ----------------------------------------------------------------------------
// Easing item queue
// Small FIFO between the front end and the curve pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eci_queue
    import eci_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  eci_item_t din,
    output logic      full,
    input  logic      pop,
    output eci_item_t dout,
    output logic      empty
);

    eci_item_t            mem_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_next;

    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    `ECI_ASSERT_NEVER(a_no_overflow, push && full, "word pushed into a full queue")
    `ECI_ASSERT_NEVER(a_no_underflow, pop && empty, "word popped from an empty queue")
    `ECI_ASSERT(a_ptrs_when_empty, empty |-> (rd_ptr_reg == wr_ptr_reg), "pointers disagree")

endmodule

[sv/eci_back.sv]
// ----------------------------------------------------------------------------
// Easing curve pipeline
// Evaluates the selected curve, rounds it to Q2.16 and blends the values.
// ----------------------------------------------------------------------------
module eci_back
    import eci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  eci_item_t   q_item,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // eased_value[23:0]
    output logic [23:0] m_axis_tdata,
    // saturated[0]
    output logic        m_axis_tuser
);

    localparam logic signed [32:0] W33 = 33'sd1 <<< Q_BITS;

    logic       en;
    logic [6:0] valid_reg;

    // ---------------- stage A: arguments and power table read
    logic [PROG_W-1:0]   a_p;
    logic [PROG_W-1:0]   a_pc;
    logic [20:0]         a_t_wide;
    logic [8:0]          a_pidx;
    logic [PROG_W-1:0]   a_bin;
    logic [20:0]         a_x11;
    logic signed [21:0]  a_m;
    logic [18:0]         a_am;
    logic [Q_BITS:0]     a_base;
    logic [PROG_W-1:0]   a_uprog;
    logic [20:0]         a_p10;
    logic signed [21:0]  a_ang;
    logic signed [5:0]   a_hi;
    logic [4:0]          a_h12;
    logic [4:0]          a_hq;
    logic [1:0]          a_hm;

    eci_item_t           b_item_reg;
    logic [3:0]          b_n_reg;
    logic [7:0]          b_tf_reg;
    logic [Q_BITS:0]     b_pa_reg;
    logic [Q_BITS:0]     b_pb_reg;
    logic [18:0]         b_am_reg;
    logic [Q_BITS:0]     b_base_reg;
    logic [Q_BITS:0]     b_u_reg;
    logic [17:0]         b_r_reg;

    always_comb
    begin
        a_p  = q_item.prog;
        a_pc = PROG_ONE - q_item.prog;
        unique case (q_item.curve) inside
            MODE_EXPO_IN, MODE_ELASTIC_IN:
                a_t_wide = 21'd10 * 21'(a_pc);
            MODE_EXPO_OUT, MODE_ELASTIC_OUT:
                a_t_wide = 21'd10 * 21'(a_p);
            MODE_EXPO_INOUT:
                a_t_wide = (a_p < PROG_HALF) ? 21'd655360 - 21'd20 * 21'(a_p)
                                             : 21'd20 * 21'(a_p) - 21'd655360;
            default:
                a_t_wide = '0;
        endcase
        a_pidx = {1'b0, a_t_wide[15:8]};

        // Bounce works on 11x in progress units; the square is scaled later.
        a_bin = (q_item.curve == MODE_BOUNCE_IN) ? a_pc : a_p;
        a_x11 = 21'd11 * 21'(a_bin);
        if (a_x11 < 21'd262144)
        begin
            a_m    = $signed({1'b0, a_x11});
            a_base = '0;
        end
        else if (a_x11 < 21'd524288)
        begin
            a_m    = $signed({1'b0, a_x11}) - 22'sd393216;
            a_base = (Q_BITS + 1)'(3) << 28;
        end
        else if (a_x11 < 21'd655360)
        begin
            a_m    = $signed({1'b0, a_x11}) - 22'sd589824;
            a_base = (Q_BITS + 1)'(15) << 26;
        end
        else
        begin
            a_m    = $signed({1'b0, a_x11}) - 22'sd688128;
            a_base = (Q_BITS + 1)'(63) << 24;
        end
        a_am = (a_m < 0) ? 19'(-a_m) : 19'(a_m);

        unique case (q_item.curve) inside
            MODE_CUBIC_OUT:
                a_uprog = a_pc;
            MODE_CUBIC_INOUT:
                a_uprog = (a_p < PROG_HALF) ? a_p : PROG_W'({a_pc, 1'b0});
            default:
                a_uprog = a_p;
        endcase

        // Sine phase in units of 2^-16 of W, reduced modulo one turn (three units of W).
        a_p10 = 21'd10 * 21'(a_p);
        a_ang = $signed({1'b0, a_p10}) -
                ((q_item.curve == MODE_ELASTIC_IN) ? 22'sd704512 : 22'sd49152);
        a_hi  = 6'(a_ang >>> 16);
        a_h12 = 5'(a_hi + 6'sd12);
        a_hq  = 5'((8'(a_h12) * 8'd11) >> 5);
        a_hm  = 2'(a_h12 - 5'd3 * a_hq);
    end

    // ---------------- stage B: power interpolation, squares, divide by three
    logic signed [31:0]  b_d;
    logic signed [40:0]  b_prod;
    logic signed [31:0]  b_v;
    logic [Q_BITS:0]     b_pow;
    logic [37:0]         b_sq;
    logic [31:0]         b_bo;
    logic [61:0]         b_uu;
    logic [35:0]         b_rq;
    logic [16:0]         b_q;
    logic [1:0]          b_mod;

    eci_item_t           c_item_reg;
    logic [Q_BITS:0]     c_pow_reg;
    logic [Q_BITS:0]     c_bo_reg;
    logic [Q_BITS:0]     c_c1_reg;
    logic [Q_BITS:0]     c_u_reg;
    logic [15:0]         c_q_reg;
    logic [1:0]          c_m_reg;

    always_comb
    begin
        b_d    = $signed({1'b0, b_pb_reg}) - $signed({1'b0, b_pa_reg});
        b_prod = b_d * $signed({1'b0, b_tf_reg});
        b_v    = $signed({1'b0, b_pa_reg}) + 32'(b_prod >>> 8);
        b_pow  = (b_v < 0) ? '0 : (Q_BITS + 1)'($unsigned(b_v) >> b_n_reg);
        b_sq   = 38'(b_am_reg) * 38'(b_am_reg);
        b_bo   = 32'(b_sq >> 6) + 32'(b_base_reg);
        b_uu   = 62'(b_u_reg) * 62'(b_u_reg);
        // Exact quotient by three for an 18-bit phase.
        b_rq   = 36'(b_r_reg) * 36'd174763;
        b_q    = 17'(b_rq >> 19);
        b_mod  = 2'(b_r_reg - 18'(b_q) * 18'd3);
    end

    // ---------------- stage C: sine table read, second cubic product
    logic [23:0]         c_mt;
    logic [37:0]         c_qp0;
    logic [38:0]         c_qp;
    logic [TBL_AW-1:0]   c_sidx;
    logic [TBL_AW-1:0]   c_sidx_b;
    logic [61:0]         c_cc;

    eci_item_t           d_item_reg;
    logic [Q_BITS:0]     d_pow_reg;
    logic [Q_BITS:0]     d_bo_reg;
    logic [Q_BITS:0]     d_c2_reg;
    logic [Q_BITS:0]     d_sa_reg;
    logic [Q_BITS:0]     d_sb_reg;
    logic [29:0]         d_srem_reg;
    logic                d_neg_reg;

    always_comb
    begin
        case (c_m_reg)
            2'd0:    c_mt = '0;
            2'd1:    c_mt = 24'd5592405;
            default: c_mt = 24'd11184810;
        endcase
        c_qp0 = {c_q_reg[13:0], c_mt};
        // Odd quadrants run the quarter table backward.
        c_qp  = c_q_reg[14] ? (39'(1) << 38) - {1'b0, c_qp0} : {1'b0, c_qp0};
        c_sidx   = c_qp[38:30];
        c_sidx_b = (c_sidx == TBL_AW'(TABLE_DEPTH)) ? c_sidx : c_sidx + 1'b1;
        c_cc     = 62'(c_c1_reg) * 62'(c_u_reg);
    end

    // ---------------- stage D: sine interpolation, closed-form curves
    logic [60:0]         d_sprod;
    logic [Q_BITS:0]     d_sv;
    logic signed [31:0]  d_sin;
    logic signed [32:0]  d_x;
    logic signed [32:0]  d_pw;
    logic signed [32:0]  d_c2;
    logic signed [32:0]  d_bo;
    logic signed [32:0]  d_eq;

    eci_item_t           e_item_reg;
    logic signed [32:0]  e_base_reg;
    logic signed [31:0]  e_sin_reg;
    logic [Q_BITS:0]     e_pow_reg;

    always_comb
    begin
        d_sprod = 61'(d_sb_reg - d_sa_reg) * 61'(d_srem_reg);
        d_sv    = d_sa_reg + (Q_BITS + 1)'(d_sprod >> 30);
        d_sin   = d_neg_reg ? -$signed({1'b0, d_sv}) : $signed({1'b0, d_sv});
        d_x     = $signed({2'b0, d_item_reg.prog, 14'b0});
        d_pw    = $signed({2'b0, d_pow_reg});
        d_c2    = $signed({2'b0, d_c2_reg});
        d_bo    = $signed({2'b0, d_bo_reg});
        unique case (d_item_reg.curve) inside
            MODE_EXPO_IN:
                d_eq = d_item_reg.is_zero ? '0 : d_pw;
            MODE_EXPO_OUT:
                d_eq = d_item_reg.is_one ? W33 : W33 - d_pw;
            MODE_EXPO_INOUT:
                if (d_item_reg.is_zero)
                    d_eq = '0;
                else if (d_item_reg.is_one)
                    d_eq = W33;
                else if (d_item_reg.prog < PROG_HALF)
                    d_eq = d_pw >>> 1;
                else
                    d_eq = W33 - (d_pw >>> 1);
            MODE_CUBIC_IN:
                d_eq = d_c2;
            MODE_CUBIC_OUT:
                d_eq = W33 - d_c2;
            MODE_CUBIC_INOUT:
                d_eq = (d_item_reg.prog < PROG_HALF) ? (d_c2 <<< 2) : W33 - (d_c2 >>> 1);
            MODE_BOUNCE_OUT:
                d_eq = d_bo;
            MODE_BOUNCE_IN:
                d_eq = W33 - d_bo;
            default:
                d_eq = d_x;
        endcase
    end

    // ---------------- stage E: elastic product
    logic signed [63:0]  e_el;
    logic signed [32:0]  e_flr;
    logic signed [32:0]  e_eq;

    eci_item_t           f_item_reg;
    logic signed [32:0]  f_eq_reg;

    always_comb
    begin
        e_el  = $signed({1'b0, e_pow_reg}) * e_sin_reg;
        e_flr = 33'(e_el >>> 30);
        if ((e_item_reg.curve == MODE_ELASTIC_IN) || (e_item_reg.curve == MODE_ELASTIC_OUT))
        begin
            if (e_item_reg.is_zero)
                e_eq = '0;
            else if (e_item_reg.is_one)
                e_eq = W33;
            else if (e_item_reg.curve == MODE_ELASTIC_IN)
                e_eq = -e_flr;
            else
                e_eq = W33 + e_flr;
        end
        else
            e_eq = e_base_reg;
    end

    // ---------------- stage F: round to Q2.16 and blend product
    logic signed [32:0]  f_rnd;
    logic signed [17:0]  f_ef;
    logic signed [24:0]  f_diff;
    logic signed [42:0]  f_prod;

    logic signed [42:0]            g_prod_reg;
    logic signed [VALUE_WIDTH-1:0] g_start_reg;

    always_comb
    begin
        f_rnd = (f_eq_reg + 33'sd8192) >>> 14;
        if (f_rnd > 33'sd131071)
            f_ef = 18'sd131071;
        else if (f_rnd < -33'sd131072)
            f_ef = -18'sd131072;
        else
            f_ef = 18'(f_rnd);
        f_diff = $signed({f_item_reg.end_value[VALUE_WIDTH-1], f_item_reg.end_value}) -
                 $signed({f_item_reg.start_value[VALUE_WIDTH-1], f_item_reg.start_value});
        f_prod = f_diff * f_ef;
    end

    // ---------------- stage G: final add and saturation
    logic signed [27:0]  g_res;
    logic [23:0]         g_value;
    logic                g_sat;

    logic [23:0]         out_value_reg;
    logic                out_sat_reg;

    always_comb
    begin
        g_res = 28'(g_start_reg) + 28'((g_prod_reg + 43'sd32768) >>> 16);
        if (g_res > 28'sd8388607)
        begin
            g_value = 24'h7FFFFF;
            g_sat   = 1'b1;
        end
        else if (g_res < -28'sd8388608)
        begin
            g_value = 24'h800000;
            g_sat   = 1'b1;
        end
        else
        begin
            g_value = g_res[23:0];
            g_sat   = 1'b0;
        end
    end

    // The whole pipeline moves together; it holds only while the output waits.
    assign en  = !valid_reg[6] || m_axis_tready;
    assign pop = en && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[5:0], !q_empty};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_item_reg    <= q_item;
            b_n_reg       <= a_t_wide[19:16];
            b_tf_reg      <= a_t_wide[7:0];
            b_pa_reg      <= POW2_ROM[a_pidx];
            b_pb_reg      <= POW2_ROM[a_pidx + 1'b1];
            b_am_reg      <= a_am;
            b_base_reg    <= a_base;
            b_u_reg       <= {a_uprog, 14'b0};
            b_r_reg       <= {a_hm, a_ang[15:0]};

            c_item_reg    <= b_item_reg;
            c_pow_reg     <= b_pow;
            c_bo_reg      <= (Q_BITS + 1)'(b_bo);
            c_c1_reg      <= b_uu[60:30];
            c_u_reg       <= b_u_reg;
            c_q_reg       <= b_q[15:0];
            c_m_reg       <= b_mod;

            d_item_reg    <= c_item_reg;
            d_pow_reg     <= c_pow_reg;
            d_bo_reg      <= c_bo_reg;
            d_c2_reg      <= c_cc[60:30];
            d_sa_reg      <= SIN_ROM[c_sidx];
            d_sb_reg      <= SIN_ROM[c_sidx_b];
            d_srem_reg    <= c_qp[29:0];
            d_neg_reg     <= c_q_reg[15];

            e_item_reg    <= d_item_reg;
            e_base_reg    <= d_eq;
            e_sin_reg     <= d_sin;
            e_pow_reg     <= d_pow_reg;

            f_item_reg    <= e_item_reg;
            f_eq_reg      <= e_eq;

            g_prod_reg    <= f_prod;
            g_start_reg   <= f_item_reg.start_value;

            out_value_reg <= g_value;
            out_sat_reg   <= g_sat;
        end
    end

    assign m_axis_tvalid = valid_reg[6];
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule

[tb/sv/eci_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve checker
// Watches both stream channels of the interpolator, predicts each eased value
// from the accepted input word and compares it with the output in order.
// ----------------------------------------------------------------------------
module eci_checker
    import eci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          errors,
    output int          waiting
);

    localparam longint ONE_Q = 64'sd1 <<< 30;
    localparam longint unsigned FRAC_MASK = (64'd1 << 30) - 1;

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          sat;
    } blend_t;

    longint exp_table [0:TABLE_DEPTH];
    longint sine_table [0:TABLE_DEPTH];
    blend_t blend_q[$];

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    initial
    begin
        longint unsigned y;
        longint unsigned term;
        longint unsigned z2;
        longint          acc;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            y    = (longint'(i) * 744261118 + TABLE_DEPTH / 2) / TABLE_DEPTH;
            term = ONE_Q;
            acc  = ONE_Q;
            for (int k = 1; k <= 14; k++)
            begin
                term = ((term * y) >> 30) / k;
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            exp_table[i] = (acc < 0) ? 0 : (acc > ONE_Q) ? ONE_Q : acc;

            y    = (longint'(i) * 1686629713 + TABLE_DEPTH / 2) / TABLE_DEPTH;
            z2   = (y * y) >> 30;
            term = y;
            acc  = longint'(y);
            for (int k = 1; k <= 10; k++)
            begin
                term = ((term * z2) >> 30) / ((2 * k) * (2 * k + 1));
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            sine_table[i] = (acc < 0) ? 0 : (acc > ONE_Q) ? ONE_Q : acc;
        end
    end

    // 2^-t with t in Q30, interpolated between table entries.
    function automatic longint exp2_neg(longint unsigned t);
        longint unsigned whole;
        longint unsigned pos;
        int              idx;
        longint          a;
        longint          v;
        whole = t >> 30;
        if (whole >= 31)
            return 0;
        pos = (t & FRAC_MASK) * TABLE_DEPTH;
        idx = int'(pos >> 30);
        a   = exp_table[idx];
        v   = a + floor_div((exp_table[idx+1] - a) * longint'(pos & FRAC_MASK), 30);
        if (v < 0)
            v = 0;
        return v >>> whole;
    endfunction

    // Sine of a phase of ph / (3 * 2^30) turns, from the quarter-wave table.
    function automatic longint sine_turns(longint ph);
        longint          period;
        longint          r;
        longint unsigned p;
        longint unsigned quad;
        longint unsigned qp;
        int              idx;
        longint          v;
        longint          a;
        period = 3 * ONE_Q;
        r      = ((ph % period) + period) % period;
        p      = longint'(r) * 4 * TABLE_DEPTH / 3;
        quad   = ((p >> 30) / TABLE_DEPTH) & 3;
        qp     = p - ((quad * TABLE_DEPTH) << 30);
        if (quad[0])
            qp = (longint'(TABLE_DEPTH) << 30) - qp;
        idx = int'(qp >> 30);
        if (idx >= TABLE_DEPTH)
            v = sine_table[TABLE_DEPTH];
        else
        begin
            a = sine_table[idx];
            v = a + floor_div((sine_table[idx+1] - a) * longint'(qp & FRAC_MASK), 30);
        end
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint bounce(longint x);
        longint          x11;
        longint          m;
        longint          base;
        longint unsigned am;
        x11 = 11 * x;
        if (x11 < 4 * ONE_Q)
        begin
            m = x11; base = 0;
        end
        else if (x11 < 8 * ONE_Q)
        begin
            m = x11 - 6 * ONE_Q; base = 3 * ONE_Q / 4;
        end
        else if (x11 < 10 * ONE_Q)
        begin
            m = x11 - 9 * ONE_Q; base = 15 * ONE_Q / 16;
        end
        else
        begin
            m = x11 - 21 * ONE_Q / 2; base = 63 * ONE_Q / 64;
        end
        am = (m < 0) ? -m : m;
        return longint'((am * am) >> 34) + base;
    endfunction

    function automatic longint curve_q30(logic [3:0] mode, longint x);
        longint unsigned u;
        case (mode)
            MODE_EXPO_IN:
                return (x == 0) ? 0 : exp2_neg(10 * (ONE_Q - x));
            MODE_EXPO_OUT:
                return (x == ONE_Q) ? ONE_Q : ONE_Q - exp2_neg(10 * x);
            MODE_EXPO_INOUT:
            begin
                if (x == 0)
                    return 0;
                if (x == ONE_Q)
                    return ONE_Q;
                if (x < ONE_Q / 2)
                    return exp2_neg(10 * ONE_Q - 20 * x) >>> 1;
                return ONE_Q - (exp2_neg(20 * x - 10 * ONE_Q) >>> 1);
            end
            MODE_CUBIC_IN:
                return longint'(qmul(qmul(x, x), x));
            MODE_CUBIC_OUT:
            begin
                u = ONE_Q - x;
                return ONE_Q - longint'(qmul(qmul(u, u), u));
            end
            MODE_CUBIC_INOUT:
            begin
                if (x < ONE_Q / 2)
                    return 4 * longint'(qmul(qmul(x, x), x));
                u = 2 * ONE_Q - 2 * x;
                return ONE_Q - longint'(qmul(qmul(u, u), u) >> 1);
            end
            MODE_BOUNCE_OUT:
                return bounce(x);
            MODE_BOUNCE_IN:
                return ONE_Q - bounce(ONE_Q - x);
            MODE_ELASTIC_IN:
            begin
                if (x == 0)
                    return 0;
                if (x == ONE_Q)
                    return ONE_Q;
                return -floor_div(exp2_neg(10 * ONE_Q - 10 * x)
                                  * sine_turns(10 * x - 43 * ONE_Q / 4), 30);
            end
            MODE_ELASTIC_OUT:
            begin
                if (x == 0)
                    return 0;
                if (x == ONE_Q)
                    return ONE_Q;
                return ONE_Q + floor_div(exp2_neg(10 * x)
                                         * sine_turns(10 * x - 3 * ONE_Q / 4), 30);
            end
            default:
                return x;
        endcase
    endfunction

    function automatic blend_t predict_blend(logic [71:0] word);
        logic [3:0]   mode;
        longint       prog;
        longint       sv;
        longint       ev;
        longint       ef;
        longint       r;
        longint       one;
        blend_t       b;
        mode = word[3:0];
        prog = longint'(word[20:4]);
        sv   = longint'($signed(word[44:21]));
        ev   = longint'($signed(word[68:45]));
        one  = 64'sd1 <<< FRACTION_BITS;
        if (prog > one)
            prog = one;
        ef = floor_div(curve_q30(mode, prog <<< (30 - FRACTION_BITS))
                       + (64'sd1 <<< (29 - FRACTION_BITS)), 30 - FRACTION_BITS);
        if (ef < -2 * one)
            ef = -2 * one;
        if (ef > 2 * one - 1)
            ef = 2 * one - 1;
        r = sv + floor_div((ev - sv) * ef + (one >>> 1), FRACTION_BITS);
        b.sat = 1'b0;
        if (r > 8388607)
        begin
            r = 8388607; b.sat = 1'b1;
        end
        if (r < -8388608)
        begin
            r = -8388608; b.sat = 1'b1;
        end
        b.value = r[VALUE_WIDTH-1:0];
        return b;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    initial
        errors = 0;

    assign waiting = blend_q.size();

    always @(posedge clk)
    begin
        blend_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                blend_q.push_back(predict_blend(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (blend_q.size() == 0)
                    report_mismatch("output word with no input pending");
                else
                begin
                    want = blend_q.pop_front();
                    if (m_axis_tdata !== want.value)
                        report_mismatch($sformatf("eased_value got %0d want %0d",
                                        $signed(m_axis_tdata), want.value));
                    if (m_axis_tuser !== want.sat)
                        report_mismatch($sformatf("saturated got %b want %b",
                                        m_axis_tuser, want.sat));
                end
            end
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve interpolator testbench
// Drives directed and random words with random idling on both channels and
// leaves all checking to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    import eci_pkg::*;

    localparam int RANDOM_WORDS = 830;
    localparam int QUIET_TAIL   = 120;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          errors;
    int          waiting;
    int          cycles;
    logic        idling;
    int          stall_left;

    easing_curve_interpolator u_top (.*);

    eci_checker u_chk (.*);

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output stalls come in bursts while idling is enabled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(1, 15);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_word(logic [3:0] mode, logic [16:0] prog,
                             logic [23:0] sv, logic [23:0] ev);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, ev, sv, prog, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [23:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($urandom_range(0, 2000)) - 24'd1000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] pick_progress();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return PROG_ONE;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        logic [3:0] m;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;
        cycles        = 0;
        idling        = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every curve including unknown codes, at the ends and past one.
        for (int i = 0; i < 16; i++)
        begin
            m = 4'(i);
            send_word(m, (i % 4 == 0) ? 17'd0 : (i % 4 == 1) ? PROG_ONE
                         : (i % 4 == 2) ? 17'h1ffff : PROG_HALF,
                      24'h800000, 24'h7fffff);
        end
        // Elastic overshoot on the full range saturates both ways.
        send_word(MODE_ELASTIC_OUT, 17'd8000, 24'h800000, 24'h7fffff);
        send_word(MODE_ELASTIC_OUT, 17'd8000, 24'h7fffff, 24'h800000);
        send_word(MODE_ELASTIC_IN, 17'd60000, 24'h7fffff, 24'h800000);
        send_word(MODE_BOUNCE_IN, 17'd1, 24'd5, 24'd5);
        send_word(MODE_EXPO_INOUT, PROG_HALF, 24'd0, 24'd100);
        send_word(MODE_CUBIC_INOUT, PROG_HALF - 17'd1, 24'h7fffff, 24'h7fffff);
        send_word(MODE_LINEAR, 17'd1, 24'h000000, 24'hffffff);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS - QUIET_TAIL)
                idling = 1'b0;
            send_word(4'($urandom_range(0, 15)), pick_progress(),
                      pick_value(), pick_value());
        end
        s_axis_tvalid <= 1'b0;

        while (waiting != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
